// ----- rtl/ciir_pkg.sv -----
package ciir_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int INTERNAL_BITS  = 32;
    localparam int DATA_FRAC_BITS = INTERNAL_BITS - SAMPLE_BITS;
    localparam int COEF_BITS      = 18;

    localparam int DIGIT_BITS     = 2;
    localparam int NUM_DIGITS     = COEF_BITS / DIGIT_BITS;
    localparam int DIGIT_CNT_BITS = $clog2(NUM_DIGITS);
    localparam int TERM_BITS      = INTERNAL_BITS + DIGIT_BITS + 1;
    localparam int ACC_BITS       = INTERNAL_BITS + COEF_BITS;
    localparam int PROD_BITS      = ACC_BITS - COEF_FRAC_BITS;
    localparam int SUM_BITS       = INTERNAL_BITS + 4;
    localparam int ROUND_BITS     = INTERNAL_BITS + 1;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_GAIN     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIQUAD_FB_ONE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIQUAD_FB_TWO  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_GAIN    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_ORDER_FB = 3'd4;

    localparam logic signed [COEF_BITS-1:0] FIRST_GAIN_RESET     = COEF_BITS'(916);
    localparam logic signed [COEF_BITS-1:0] BIQUAD_FB_ONE_RESET  = COEF_BITS'(-112914);
    localparam logic signed [COEF_BITS-1:0] BIQUAD_FB_TWO_RESET  = COEF_BITS'(51040);
    localparam logic signed [COEF_BITS-1:0] SECOND_GAIN_RESET    = COEF_BITS'(7351);
    localparam logic signed [COEF_BITS-1:0] FIRST_ORDER_FB_RESET = COEF_BITS'(-50835);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_ROUND,
        ST_DELIVER
    } state_t;

    typedef enum logic [2:0] {
        PH_GAIN_IN,
        PH_FB_ONE,
        PH_FB_TWO,
        PH_GAIN_MID,
        PH_FB_SECTION
    } phase_t;

    function automatic logic signed [INTERNAL_BITS-1:0] sat_internal(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-INTERNAL_BITS:0] upper;
        logic signed [INTERNAL_BITS-1:0] res;
        upper = v[SUM_BITS-1:INTERNAL_BITS-1];
        if ((&upper) || !(|upper)) begin
            res = v[INTERNAL_BITS-1:0];
        end else if (v[SUM_BITS-1]) begin
            res = {1'b1, {(INTERNAL_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(INTERNAL_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ----- rtl/ciir_serial_mul.sv -----
module ciir_serial_mul (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic signed [ciir_pkg::INTERNAL_BITS-1:0] mul_value,
    input  logic signed [ciir_pkg::COEF_BITS-1:0]     mul_coef,
    output logic                                    done,
    output logic signed [ciir_pkg::PROD_BITS-1:0]     product
);
    import ciir_pkg::*;

    // Coefficient digits are taken most significant first; the result is the
    // product rounded half up to the data fraction.
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [DIGIT_CNT_BITS-1:0] LAST_DIGIT = DIGIT_CNT_BITS'(NUM_DIGITS - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [DIGIT_CNT_BITS-1:0]        cnt_reg;
    logic signed [INTERNAL_BITS-1:0]  value_reg;
    logic [COEF_BITS-1:0]             coef_reg;
    logic signed [ACC_BITS-1:0]       acc_reg;
    logic signed [ACC_BITS-1:0]       acc_next;

    logic [DIGIT_BITS-1:0]            digit_raw;
    logic signed [DIGIT_BITS:0]       digit;
    logic signed [TERM_BITS-1:0]      term;
    logic                             last_digit;

    always_comb begin
        digit_raw  = coef_reg[COEF_BITS-1 -: DIGIT_BITS];
        last_digit = (cnt_reg == LAST_DIGIT);
        if (cnt_reg == '0) begin
            digit = {digit_raw[DIGIT_BITS-1], digit_raw};
        end else begin
            digit = {1'b0, digit_raw};
        end
        term     = value_reg * digit;
        acc_next = (acc_reg <<< DIGIT_BITS)
                 + {{(ACC_BITS-TERM_BITS){term[TERM_BITS-1]}}, term}
                 + (last_digit ? ROUND_HALF : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last_digit;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIGIT_CNT_BITS'(1);
                if (last_digit) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            value_reg <= mul_value;
            coef_reg  <= mul_coef;
            acc_reg   <= '0;
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            coef_reg <= coef_reg << DIGIT_BITS;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[ACC_BITS-1:COEF_FRAC_BITS];

endmodule

// ----- rtl/cascaded_iir_lowpass_unit.sv -----
// Channel   Direction  Ports                                   Beat carries
// s_        in         s_valid s_ready s_kind s_sample_in      one sample or a clear
// m_        out        m_valid m_ready m_sample_out            one filtered sample
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  one coefficient write
//
// A sample beat runs five coefficient products one after another through a single
// radix-4 shift-and-add multiplier. A clear beat zeroes the filter history and
// delivers a zero output sample. The output register lets the next beat be taken
// while a result still waits. Reset restores the default coefficients and zeroes
// all filter history. A stalled output holds the sequencer before its last step.
module cascaded_iir_lowpass_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_kind,
    input  logic signed [ciir_pkg::SAMPLE_BITS-1:0]  s_sample_in,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [ciir_pkg::SAMPLE_BITS-1:0]  m_sample_out,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ciir_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [ciir_pkg::COEF_BITS-1:0]           cfg_data
);
    import ciir_pkg::*;

    localparam logic signed [ROUND_BITS-1:0] OUT_HALF = ROUND_BITS'(1) << (DATA_FRAC_BITS - 1);

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic signed [COEF_BITS-1:0]     first_gain_reg;
    logic signed [COEF_BITS-1:0]     biquad_fb_one_reg;
    logic signed [COEF_BITS-1:0]     biquad_fb_two_reg;
    logic signed [COEF_BITS-1:0]     second_gain_reg;
    logic signed [COEF_BITS-1:0]     first_order_fb_reg;

    logic signed [INTERNAL_BITS-1:0] bq_in_one_reg;
    logic signed [INTERNAL_BITS-1:0] bq_in_two_reg;
    logic signed [INTERNAL_BITS-1:0] bq_out_one_reg;
    logic signed [INTERNAL_BITS-1:0] bq_out_two_reg;
    logic signed [INTERNAL_BITS-1:0] sec_in_reg;
    logic signed [INTERNAL_BITS-1:0] sec_out_reg;

    logic signed [INTERNAL_BITS-1:0] x_reg;
    logic signed [INTERNAL_BITS-1:0] g0_reg;
    logic signed [SUM_BITS-1:0]      sum_reg;
    logic signed [SAMPLE_BITS-1:0]   result_reg;
    logic                            m_valid_reg;
    logic signed [SAMPLE_BITS-1:0]   m_sample_out_reg;

    logic                            in_beat;
    logic                            out_load;
    logic                            mul_start;
    logic                            mul_done;
    logic signed [INTERNAL_BITS-1:0] mul_value;
    logic signed [COEF_BITS-1:0]     mul_coef;
    logic signed [PROD_BITS-1:0]     product;
    logic signed [SUM_BITS-1:0]      prod_ext;
    logic signed [SUM_BITS-1:0]      sum_less_prod;
    logic signed [INTERNAL_BITS-1:0] prod_sat;
    logic signed [INTERNAL_BITS-1:0] diff_sat;
    logic signed [ROUND_BITS-1:0]    round_sum;
    logic signed [SAMPLE_BITS:0]     round_val;
    logic signed [SAMPLE_BITS-1:0]   round_sat;

    ciir_serial_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mul_start),
        .mul_value (mul_value),
        .mul_coef  (mul_coef),
        .done      (mul_done),
        .product   (product)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_kind ? ST_DELIVER : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    state_next = (phase_reg == PH_FB_SECTION) ? ST_ROUND : ST_ISSUE;
                end
            end
            ST_ROUND: begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:    s_ready   = 1'b1;
            ST_ISSUE:   mul_start = 1'b1;
            ST_DELIVER: out_load  = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (phase_reg)
            PH_GAIN_IN: begin
                mul_value = x_reg;
                mul_coef  = first_gain_reg;
            end
            PH_FB_ONE: begin
                mul_value = bq_out_one_reg;
                mul_coef  = biquad_fb_one_reg;
            end
            PH_FB_TWO: begin
                mul_value = bq_out_two_reg;
                mul_coef  = biquad_fb_two_reg;
            end
            PH_GAIN_MID: begin
                mul_value = bq_out_one_reg;
                mul_coef  = second_gain_reg;
            end
            PH_FB_SECTION: begin
                mul_value = sec_out_reg;
                mul_coef  = first_order_fb_reg;
            end
            default: begin
                mul_value = x_reg;
                mul_coef  = first_gain_reg;
            end
        endcase
    end

    always_comb begin
        in_beat       = s_valid && s_ready;
        prod_ext      = SUM_BITS'(product);
        sum_less_prod = sum_reg - prod_ext;
        prod_sat      = sat_internal(prod_ext);
        diff_sat      = sat_internal(sum_less_prod);
        round_sum     = ROUND_BITS'(sec_out_reg) + OUT_HALF;
        round_val     = round_sum[ROUND_BITS-1:DATA_FRAC_BITS];
        if (round_val[SAMPLE_BITS] != round_val[SAMPLE_BITS-1]) begin
            round_sat = round_val[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                               : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            round_sat = round_val[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            phase_reg          <= PH_GAIN_IN;
            m_valid_reg        <= 1'b0;
            first_gain_reg     <= FIRST_GAIN_RESET;
            biquad_fb_one_reg  <= BIQUAD_FB_ONE_RESET;
            biquad_fb_two_reg  <= BIQUAD_FB_TWO_RESET;
            second_gain_reg    <= SECOND_GAIN_RESET;
            first_order_fb_reg <= FIRST_ORDER_FB_RESET;
            bq_in_one_reg      <= '0;
            bq_in_two_reg      <= '0;
            bq_out_one_reg     <= '0;
            bq_out_two_reg     <= '0;
            sec_in_reg         <= '0;
            sec_out_reg        <= '0;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    REG_FIRST_GAIN:     first_gain_reg     <= cfg_data;
                    REG_BIQUAD_FB_ONE:  biquad_fb_one_reg  <= cfg_data;
                    REG_BIQUAD_FB_TWO:  biquad_fb_two_reg  <= cfg_data;
                    REG_SECOND_GAIN:    second_gain_reg    <= cfg_data;
                    REG_FIRST_ORDER_FB: first_order_fb_reg <= cfg_data;
                    default: begin
                        first_gain_reg <= first_gain_reg;
                    end
                endcase
            end

            if (in_beat) begin
                phase_reg <= PH_GAIN_IN;
                if (s_kind) begin
                    bq_in_one_reg  <= '0;
                    bq_in_two_reg  <= '0;
                    bq_out_one_reg <= '0;
                    bq_out_two_reg <= '0;
                    sec_in_reg     <= '0;
                    sec_out_reg    <= '0;
                end
            end else if (state_reg == ST_WAIT && mul_done) begin
                phase_reg <= phase_t'(phase_reg + 3'd1);
                case (phase_reg)
                    PH_FB_TWO: begin
                        bq_in_two_reg  <= bq_in_one_reg;
                        bq_in_one_reg  <= g0_reg;
                        bq_out_two_reg <= bq_out_one_reg;
                        bq_out_one_reg <= diff_sat;
                    end
                    PH_GAIN_MID: begin
                        sec_in_reg <= prod_sat;
                    end
                    PH_FB_SECTION: begin
                        sec_out_reg <= diff_sat;
                    end
                    default: begin
                        sec_in_reg <= sec_in_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            x_reg      <= {s_sample_in, {DATA_FRAC_BITS{1'b0}}};
            result_reg <= '0;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            case (phase_reg)
                PH_GAIN_IN: begin
                    g0_reg  <= prod_sat;
                    sum_reg <= SUM_BITS'(prod_sat) + (SUM_BITS'(bq_in_one_reg) <<< 1)
                             + SUM_BITS'(bq_in_two_reg);
                end
                PH_FB_ONE: begin
                    sum_reg <= sum_less_prod;
                end
                PH_GAIN_MID: begin
                    sum_reg <= SUM_BITS'(prod_sat) + SUM_BITS'(sec_in_reg);
                end
                default: begin
                    sum_reg <= sum_reg;
                end
            endcase
        end
        if (state_reg == ST_ROUND) begin
            result_reg <= round_sat;
        end
        if (out_load) begin
            m_sample_out_reg <= result_reg;
        end
    end

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

endmodule
